/* hdl/crc_checked_frame_receiver_assert.svh */
// Assertion helpers shared by the receiver modules.
`ifndef CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRCFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in receiver");

// Consequent must hold in the cycle after the antecedent.
`define CRCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in receiver");

`endif

/* hdl/crcfr_pkg.sv */
package crcfr_pkg;

    localparam int MAX_FRAME_BYTES = 512;
    localparam int LEN_W = 10;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] MIN_FRAME = 16'd10;
    localparam logic [15:0] WAIT_LIMIT_RST = 16'd1000;
    localparam logic [15:0] WAIT_MAX = 16'hFFFF;

    // Byte positions inside a frame, counted from the start byte.
    localparam logic [LEN_W-1:0] POS_SEQ = LEN_W'(1);
    localparam logic [LEN_W-1:0] POS_LEN_LO = LEN_W'(2);
    localparam logic [LEN_W-1:0] POS_CMD = LEN_W'(4);
    localparam logic [LEN_W-1:0] POS_ACK = LEN_W'(5);
    localparam logic [LEN_W-1:0] POS_CTRL = LEN_W'(6);
    localparam logic [LEN_W-1:0] POS_PAYLOAD = LEN_W'(8);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC     = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_BADLEN  = 2'd3
    } t_status;

    typedef enum logic {
        MODE_BYTE = 1'b0,
        MODE_TICK = 1'b1
    } t_mode;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             last;
        logic [1:0]       status;
        logic [7:0]       seq_num;
        logic [7:0]       command;
        logic [7:0]       ack_code;
        logic [7:0]       ctrl_byte;
        logic [LEN_W-1:0] frame_bytes;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

/* hdl/crc_checked_frame_receiver.sv */
// A result is registered and appears on the output in the cycle after the item that causes it is accepted.
// Throughput: one item per cycle; the input is ready whenever the output register is empty
// or being emptied in the same cycle, and the CRC step is a single byte-wide update.
// Reset (synchronous, active low): receiver returns to idle, CRC registers to 0xFF,
// wait_limit to 1000, output register emptied.
module crc_checked_frame_receiver import crcfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    t_result result;
    logic    space;

    assign o_in_ready = space;

    crcfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_in_valid && space),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (result)
    );

    crcfr_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .i_out_ready (i_out_ready),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

/* hdl/crcfr_crc16.sv */
module crcfr_crc16 import crcfr_pkg::*; (
    input  logic [7:0] i_crc_hi,
    input  logic [7:0] i_crc_lo,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc_hi,
    output logic [7:0] o_crc_lo
);

    logic [15:0] t;

    // Bitwise form of the table-driven Modbus update: the table entry for
    // (hi ^ data) is this 8-step reduction.
    always_comb begin
        t = {8'h00, i_crc_hi ^ i_data};
        for (int k = 0; k < 8; k++) begin
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        end
        o_crc_hi = i_crc_lo ^ t[7:0];
        o_crc_lo = t[15:8];
    end

endmodule

/* hdl/crcfr_parser.sv */
`include "crc_checked_frame_receiver_assert.svh"

module crcfr_parser import crcfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output t_result     o_result
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [15:0]      r_wait_limit;
    logic [15:0]      r_wait, n_wait;
    logic [LEN_W-1:0] r_count, n_count;
    logic [7:0]       r_len_lo, n_len_lo;
    logic [LEN_W-1:0] r_frame_len, n_frame_len;
    logic [7:0]       r_crc_hi, n_crc_hi;
    logic [7:0]       r_crc_lo, n_crc_lo;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_ack, n_ack;
    logic [7:0]       r_ctrl, n_ctrl;
    logic [7:0]       r_held, n_held;

    logic [7:0]       crc_hi_in, crc_lo_in, crc_hi_out, crc_lo_out;
    logic [15:0]      wait_inc;
    logic [15:0]      len_full;
    logic [LEN_W:0]   pos_plus2;
    logic [LEN_W:0]   len_ext;
    t_out_item        base_item;

    // A start byte reseeds the CRC, so idle feeds the initial value.
    assign crc_hi_in = (r_phase == PH_IDLE) ? CRC_INIT : r_crc_hi;
    assign crc_lo_in = (r_phase == PH_IDLE) ? CRC_INIT : r_crc_lo;

    crcfr_crc16 u_crc (
        .i_crc_hi (crc_hi_in),
        .i_crc_lo (crc_lo_in),
        .i_data   (i_item.rx_byte),
        .o_crc_hi (crc_hi_out),
        .o_crc_lo (crc_lo_out)
    );

    assign wait_inc  = (r_wait == WAIT_MAX) ? r_wait : r_wait + 16'd1;
    assign len_full  = {i_item.rx_byte, r_len_lo} & 16'hFFFE;
    assign pos_plus2 = {1'b0, r_count} + (LEN_W+1)'(2);
    assign len_ext   = {1'b0, r_frame_len};

    always_comb begin
        base_item              = '0;
        base_item.seq_num      = r_seq;
        base_item.command      = r_cmd;
        base_item.ack_code     = r_ack;
        base_item.ctrl_byte    = r_ctrl;
        base_item.frame_bytes  = (r_phase == PH_BODY) ? r_frame_len : '0;
    end

    always_comb begin
        n_phase     = r_phase;
        n_wait      = r_wait;
        n_count     = r_count;
        n_len_lo    = r_len_lo;
        n_frame_len = r_frame_len;
        n_crc_hi    = r_crc_hi;
        n_crc_lo    = r_crc_lo;
        n_seq       = r_seq;
        n_cmd       = r_cmd;
        n_ack       = r_ack;
        n_ctrl      = r_ctrl;
        n_held      = r_held;
        o_result    = '0;

        if (i_accept) begin
            if (i_item.mode == MODE_TICK) begin
                if (r_phase != PH_IDLE) begin
                    n_wait = wait_inc;
                    if (wait_inc > r_wait_limit) begin
                        o_result.valid       = 1'b1;
                        o_result.item        = base_item;
                        o_result.item.last   = 1'b1;
                        o_result.item.status = ST_TIMEOUT;
                        n_phase              = PH_IDLE;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (i_item.rx_byte == START_BYTE) begin
                            n_crc_hi    = crc_hi_out;
                            n_crc_lo    = crc_lo_out;
                            n_count     = POS_SEQ;
                            n_len_lo    = '0;
                            n_frame_len = '0;
                            n_seq       = '0;
                            n_cmd       = '0;
                            n_ack       = '0;
                            n_ctrl      = '0;
                            n_held      = '0;
                            n_wait      = '0;
                            n_phase     = PH_HEAD;
                        end
                    end
                    PH_HEAD: begin
                        n_crc_hi = crc_hi_out;
                        n_crc_lo = crc_lo_out;
                        n_count  = r_count + LEN_W'(1);
                        if (r_count == POS_SEQ) begin
                            n_seq = i_item.rx_byte;
                        end else if (r_count == POS_LEN_LO) begin
                            n_len_lo = i_item.rx_byte;
                        end else if (len_full < MIN_FRAME
                                     || len_full > 16'(MAX_FRAME_BYTES)) begin
                            o_result.valid       = 1'b1;
                            o_result.item        = base_item;
                            o_result.item.last   = 1'b1;
                            o_result.item.status = ST_BADLEN;
                            n_phase              = PH_IDLE;
                        end else begin
                            n_frame_len = len_full[LEN_W-1:0];
                            n_wait      = '0;
                            n_phase     = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        n_count = r_count + LEN_W'(1);
                        if (pos_plus2 < len_ext) begin
                            n_crc_hi = crc_hi_out;
                            n_crc_lo = crc_lo_out;
                            if (r_count == POS_CMD) begin
                                n_cmd = i_item.rx_byte;
                            end else if (r_count == POS_ACK) begin
                                n_ack = i_item.rx_byte;
                            end else if (r_count == POS_CTRL) begin
                                n_ctrl = i_item.rx_byte;
                            end else if (r_count >= POS_PAYLOAD) begin
                                o_result.valid             = 1'b1;
                                o_result.item              = base_item;
                                o_result.item.payload_byte = i_item.rx_byte;
                            end
                        end else if (pos_plus2 == len_ext) begin
                            n_held = i_item.rx_byte;
                        end else begin
                            o_result.valid       = 1'b1;
                            o_result.item        = base_item;
                            o_result.item.last   = 1'b1;
                            o_result.item.status =
                                (r_held == r_crc_lo && i_item.rx_byte == r_crc_hi)
                                ? ST_OK : ST_CRC;
                            n_phase              = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_wait_limit <= WAIT_LIMIT_RST;
            r_wait       <= '0;
            r_count      <= '0;
            r_len_lo     <= '0;
            r_frame_len  <= '0;
            r_crc_hi     <= CRC_INIT;
            r_crc_lo     <= CRC_INIT;
            r_seq        <= '0;
            r_cmd        <= '0;
            r_ack        <= '0;
            r_ctrl       <= '0;
            r_held       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_wait      <= n_wait;
            r_count     <= n_count;
            r_len_lo    <= n_len_lo;
            r_frame_len <= n_frame_len;
            r_crc_hi    <= n_crc_hi;
            r_crc_lo    <= n_crc_lo;
            r_seq       <= n_seq;
            r_cmd       <= n_cmd;
            r_ack       <= n_ack;
            r_ctrl      <= n_ctrl;
            r_held      <= n_held;
            if (i_cfg_we) begin
                r_wait_limit <= i_cfg_wdata;
            end
        end
    end

    `CRCFR_ASSERT_SAME(a_body_len_range, i_clk, i_rst_n, r_phase == PH_BODY,
        r_frame_len >= MIN_FRAME[LEN_W-1:0] && !r_frame_len[0])
    `CRCFR_ASSERT_SAME(a_payload_plain, i_clk, i_rst_n, o_result.valid && !o_result.item.last,
        o_result.item.status == ST_OK && r_phase == PH_BODY)
    `CRCFR_ASSERT_NEXT(a_last_ends_frame, i_clk, i_rst_n, o_result.valid && o_result.item.last,
        r_phase == PH_IDLE)

endmodule

/* hdl/crcfr_outbuf.sv */
`include "crc_checked_frame_receiver_assert.svh"

module crcfr_outbuf import crcfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_result   i_result,
    input  logic      i_out_ready,
    output logic      o_space,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic      r_valid;
    t_out_item r_item;

    // A new item may enter whenever the register is empty or the held result leaves in the same cycle.
    assign o_space     = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_item <= i_result.item;
        end
    end

    `CRCFR_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, i_result.valid, o_space)
    `CRCFR_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, i_result.valid, r_valid)
    `CRCFR_ASSERT_NEXT(a_idle_stays, i_clk, i_rst_n, !r_valid && !i_result.valid, !r_valid)

endmodule
